@@ hdl/icfc_pkg.sv @@
// Shared constants, types and codes for the instruction cache fetch-cost model.
package icfc_pkg;

	// Default cache size in words; the cache is organized as lines of four words.
	localparam int CACHE_WORDS_DEF = 1024;
	localparam int WORDS_PER_LINE  = 4;

	// Field widths of the transaction ports.
	localparam int ADDR_W   = 32;
	localparam int CYCLES_W = 3;
	localparam int CFG_IDX_W = 1;

	// Fetches at or above this address bypass the cache.
	localparam logic [ADDR_W-1:0] UNCACHED_BASE = 32'hA000_0000;

	// Cost of an uncached miss, and the cost of a cached miss that starts at word zero.
	// The cost of a cached miss at word W is REFILL_COST_W0 less W.
	localparam logic [CYCLES_W-1:0] UNCACHED_COST = 3'd4;
	localparam logic [CYCLES_W-1:0] REFILL_COST_W0 = 3'd7;
	localparam logic [CYCLES_W-1:0] HIT_COST = 3'd0;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLAY_HOLD = 1'b1;

	// Controller states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_wr;  // write one zeroed line during the clearing pass
		logic accept;    // capture the fetch address and launch the array read
		logic lookup;    // evaluate the array read, update the line, post the result
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done; // the clearing pass writes its last line this cycle
	} dp_status_t;

endpackage

@@ hdl/icache_fetch_cost_model_core.sv @@
// Top level of the instruction cache fetch-cost model: controller plus datapath.
//
// This block models the tags and per-word valid bits of a direct-mapped instruction
// cache of CACHE_WORDS words in lines of four words, and reports for each fetch
// address whether it hit, how many cycles the fetch costs and whether the pending
// load-delay give-back must be cleared. A fetch transaction is accepted at a rising
// edge where start is high and busy is low. Its result appears on hit, fetch_cycles
// and clear_load_delay for exactly one cycle, marked by done, and is registered after
// the registered array read; the receiver cannot stall, so it must sample the result
// in that cycle. A fetch occupies the block for a read of the tag and valid array,
// whose read data is registered, and then a step to compare, refill the line and post
// the result, so busy drops in the cycle the result shows and a new fetch can be taken
// then. After reset a clearing pass writes every line of the array with zero valid
// bits, one line per cycle, and busy stays high until it completes. Configuration
// writes (enable at index 0, replay_hold at index 1) are always accepted (cfg_ready is
// tied high) and are meant to be issued only while no fetch is in flight. With enable
// low or replay_hold high every fetch returns all zeros and leaves the array untouched.
`default_nettype none
module icache_fetch_cost_model_core #(
	parameter int CACHE_WORDS = icfc_pkg::CACHE_WORDS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [icfc_pkg::ADDR_W-1:0]          fetch_address,
	output logic                                      done,
	output logic                                      hit,
	output logic      [icfc_pkg::CYCLES_W-1:0]        fetch_cycles,
	output logic                                      clear_load_delay,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [icfc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic                                 cfg_data
);

	icfc_pkg::ctrl_cmd_t  cmd;
	icfc_pkg::dp_status_t status;

	// The configuration registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	icfc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.status(status),
		.cmd   (cmd)
	);

	icfc_dp #(
		.CACHE_WORDS(CACHE_WORDS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fetch_address   (fetch_address),
		.done            (done),
		.hit             (hit),
		.fetch_cycles    (fetch_cycles),
		.clear_load_delay(clear_load_delay)
	);

endmodule
`default_nettype wire

@@ hdl/icfc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module icfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ hdl/icfc_ctrl.sv @@
// Controller state machine: clearing pass after reset, then accept and lookup per fetch.
`default_nettype none
module icfc_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire icfc_pkg::dp_status_t   status,
	output icfc_pkg::ctrl_cmd_t         cmd
);

	icfc_pkg::ctrl_state_t state_q;
	icfc_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= icfc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		busy         = 1'b1;
		unique case (state_q)
			icfc_pkg::ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_done) begin
					state_d = icfc_pkg::ST_IDLE;
				end
			end
			icfc_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = icfc_pkg::ST_LOOKUP;
				end
			end
			icfc_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = icfc_pkg::ST_IDLE;
			end
			default: begin
				state_d = icfc_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/icfc_dp.sv @@
// Datapath: configuration registers, tag and valid array, hit check, refill and cost.
`default_nettype none
module icfc_dp #(
	parameter int CACHE_WORDS = icfc_pkg::CACHE_WORDS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire icfc_pkg::ctrl_cmd_t                  cmd,
	output icfc_pkg::dp_status_t                      status,
	input  wire logic                                 cfg_we,
	input  wire logic [icfc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic                                 cfg_data,
	input  wire logic [icfc_pkg::ADDR_W-1:0]          fetch_address,
	output logic                                      done,
	output logic                                      hit,
	output logic      [icfc_pkg::CYCLES_W-1:0]        fetch_cycles,
	output logic                                      clear_load_delay
);

	localparam int LINE_COUNT = CACHE_WORDS / icfc_pkg::WORDS_PER_LINE;
	localparam int IDX_W      = $clog2(LINE_COUNT);
	localparam int TAG_W      = icfc_pkg::ADDR_W - 4 - IDX_W;
	localparam int ENTRY_W    = TAG_W + icfc_pkg::WORDS_PER_LINE;

	logic                         enable_q;
	logic                         hold_q;
	logic [icfc_pkg::ADDR_W-1:0]  addr_q;
	logic [IDX_W-1:0]             clr_cnt_q;

	logic                         ram_we;
	logic [IDX_W-1:0]             ram_waddr;
	logic [ENTRY_W-1:0]           ram_wdata;
	logic [ENTRY_W-1:0]           ram_rdata;

	logic [TAG_W-1:0]             rd_tag;
	logic [3:0]                   rd_valid;
	logic [TAG_W-1:0]             cur_tag;
	logic [IDX_W-1:0]             cur_idx;
	logic [1:0]                   cur_word;
	logic                         active;
	logic                         is_hit;
	logic                         is_miss;
	logic                         uncached;
	logic [3:0]                   fill_mask;
	logic [icfc_pkg::CYCLES_W-1:0] cost;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			hold_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				icfc_pkg::CFG_ENABLE:      enable_q <= cfg_data;
				icfc_pkg::CFG_REPLAY_HOLD: hold_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clearing pass line counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign status.clear_done = (clr_cnt_q == IDX_W'(LINE_COUNT - 1));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= fetch_address;
		end
	end

	// Each entry holds the line tag above four word-valid bits.
	icfc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(LINE_COUNT)
	) u_array (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.accept),
		.raddr(fetch_address[4 +: IDX_W]),
		.rdata(ram_rdata)
	);

	always_comb begin
		rd_tag    = ram_rdata[ENTRY_W-1 -: TAG_W];
		rd_valid  = ram_rdata[3:0];
		cur_tag   = addr_q[icfc_pkg::ADDR_W-1 -: TAG_W];
		cur_idx   = addr_q[4 +: IDX_W];
		cur_word  = addr_q[3:2];
		active    = enable_q && !hold_q;
		is_hit    = active && rd_valid[cur_word] && (rd_tag == cur_tag);
		is_miss   = active && !is_hit;
		uncached  = (addr_q >= icfc_pkg::UNCACHED_BASE);
		fill_mask = 4'hF << cur_word;
		if (is_hit || !active) begin
			cost = icfc_pkg::HIT_COST;
		end else if (uncached) begin
			cost = icfc_pkg::UNCACHED_COST;
		end else begin
			cost = icfc_pkg::REFILL_COST_W0 - {1'b0, cur_word};
		end

		if (cmd.clear_wr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = cmd.lookup && is_miss && !uncached;
			ram_waddr = cur_idx;
			ram_wdata = {cur_tag, fill_mask};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.lookup;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit              <= is_hit;
			fetch_cycles     <= cost;
			clear_load_delay <= is_miss;
		end
	end

endmodule
`default_nettype wire

@@ hdl/icfc_checker.sv @@
// Port-level checker for the fetch-cost model, bound to the top level.
`default_nettype none
module icfc_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 start,
	input wire logic                                 busy,
	input wire logic                                 done,
	input wire logic                                 hit,
	input wire logic [icfc_pkg::CYCLES_W-1:0]        fetch_cycles,
	input wire logic                                 clear_load_delay
);

	// Every accepted fetch posts its result once its lookup step is through.
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted fetch did not post a result two cycles later");

	// The block is busy while a fetch is in flight.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy did not rise after a fetch was accepted");

	// One result per fetch: results never come in consecutive cycles.
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// A hit is free and never clears the load-delay give-back.
	a_hit_cost: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> (fetch_cycles == 3'd0 && !clear_load_delay))
		else $error("hit reported with a nonzero cost or a load-delay clear");

	// A counted miss is never cheaper than an uncached miss and is not a hit.
	a_miss_cost: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clear_load_delay) |-> (!hit && fetch_cycles >= 3'd4))
		else $error("miss reported with a cost below four cycles or as a hit");

endmodule

bind icache_fetch_cost_model_core icfc_checker u_icfc_checker (.*);
`default_nettype wire

@@ tb/tb_icache_fetch_cost_model_core.sv @@
// Self-checking testbench for the instruction cache fetch-cost model core.
`timescale 1ns / 100ps

module tb_icache_fetch_cost_model_core;
	import icfc_pkg::*;

	// The array geometry follows the block's default size.
	localparam int LINES = CACHE_WORDS_DEF / WORDS_PER_LINE;
	localparam int LINE_BYTES = WORDS_PER_LINE * 4;
	// Generous bound for the watchdog.
	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOWN_MISMATCHES = 10;

	// One predicted result, with the fetch address kept for the report.
	typedef struct {
		logic [ADDR_W-1:0]   addr;
		logic                hit;
		logic [CYCLES_W-1:0] cycles;
		logic                clear_ld;
	} fetch_cost_t;

	// The scoreboard keeps its own copy of the tag and valid arrays and of the two
	// configuration bits. Every accepted fetch transaction is run through that copy
	// at once, and the predicted cost waits in a queue for the block's result.
	class fetch_cost_scoreboard;
		logic [31:0] tag_mem [LINES];
		logic [3:0]  valid_mem [LINES];
		bit enabled;
		bit held;
		fetch_cost_t cost_q[$];
		int unsigned mismatches;
		int unsigned hits, refills, uncached_misses, inert;

		function new();
			foreach (valid_mem[i]) begin
				valid_mem[i] = '0;
				tag_mem[i] = '0;
			end
			enabled = 1'b1;
			held = 1'b0;
		endfunction

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic value);
			case (idx)
				CFG_ENABLE:      enabled = value;
				CFG_REPLAY_HOLD: held = value;
				default: ;
			endcase
		endfunction

		function void note_fetch(logic [ADDR_W-1:0] addr);
			fetch_cost_t cost;
			int unsigned line_no, idx, tag, word;
			line_no = addr / LINE_BYTES;
			idx = line_no % LINES;
			tag = line_no / LINES;
			word = {30'b0, addr[3:2]};
			cost.addr = addr;
			cost.hit = 1'b0;
			cost.cycles = HIT_COST;
			cost.clear_ld = 1'b0;
			if (!enabled || held) begin
				// Disabled or held: all zeros and the arrays stay as they are.
				inert++;
			end else if (valid_mem[idx][word] && tag_mem[idx] == tag) begin
				cost.hit = 1'b1;
				hits++;
			end else begin
				cost.clear_ld = 1'b1;
				if (addr >= UNCACHED_BASE) begin
					cost.cycles = UNCACHED_COST;
					uncached_misses++;
				end else begin
					// Partial refill: only the missed word and those above it become valid.
					tag_mem[idx] = tag;
					valid_mem[idx] = 4'(4'hF << word);
					cost.cycles = CYCLES_W'(3 + WORDS_PER_LINE - word);
					refills++;
				end
			end
			cost_q.push_back(cost);
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= SHOWN_MISMATCHES)
				$display("%s", msg);
		endfunction

		function void check_result(logic hit, logic [CYCLES_W-1:0] cycles, logic clear_ld);
			fetch_cost_t cost;
			if (cost_q.size() == 0) begin
				report($sformatf("Unexpected result: hit=%0d cycles=%0d clear=%0d",
					hit, cycles, clear_ld));
				return;
			end
			cost = cost_q.pop_front();
			if (hit !== cost.hit || cycles !== cost.cycles || clear_ld !== cost.clear_ld)
				report($sformatf(
					"Mismatch at %08h: expected hit=%0d cycles=%0d clear=%0d, got %0d/%0d/%0d",
					cost.addr, cost.hit, cost.cycles, cost.clear_ld, hit, cycles, clear_ld));
		endfunction

		function int unsigned pending();
			return cost_q.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [ADDR_W-1:0]    fetch_address = '0;
	logic                 done;
	logic                 hit;
	logic [CYCLES_W-1:0]  fetch_cycles;
	logic                 clear_load_delay;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic                 cfg_data = 1'b0;

	fetch_cost_scoreboard sb;
	bit gaps_on = 1'b1;
	int unsigned cycle_count = 0;
	int unsigned settings_seen = 0;
	int unsigned fetches_sent = 0;

	// Working set of tags and line indexes; refreshed per phase so that random
	// fetches keep landing on a few lines and produce hits and conflicts.
	int unsigned tag_pool [4];
	int unsigned idx_pool [8];

	icache_fetch_cost_model_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.fetch_address    (fetch_address),
		.done             (done),
		.hit              (hit),
		.fetch_cycles     (fetch_cycles),
		.clear_load_delay (clear_load_delay),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #10 clk = ~clk;

	// Monitor: everything is sampled at the rising edge, before the edge's own
	// updates land, so the values seen are the ones the block acted on.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.apply_reg(cfg_index, cfg_data);
			if (start && !busy)
				sb.note_fetch(fetch_address);
			if (done)
				sb.check_result(hit, fetch_cycles, clear_load_delay);
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, sb.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offers one fetch transaction and returns at the edge that accepts it. Start is
	// left high so that the next fetch can follow without a bubble; an idle gap is
	// what lowers it. Gaps come before the offer, so they fall on any phase of the
	// block's lookup.
	task automatic send_fetch(input logic [ADDR_W-1:0] addr);
		while (gaps_on && $urandom_range(99) < 26) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		fetch_address <= addr;
		do @(posedge clk); while (busy);
		fetches_sent++;
	endtask

	// Stops sending and waits until every outstanding result has come back and the
	// block is idle, plus a short margin for the lookup pipeline.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Offers one register write and returns at the edge that takes it; the caller
	// lowers cfg_valid once its last write is done.
	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Registers change only once the block is quiet.
	task automatic apply_setting(input logic en, input logic hold);
		drain();
		program_reg(CFG_ENABLE, en);
		program_reg(CFG_REPLAY_HOLD, hold);
		cfg_valid <= 1'b0;
		settings_seen++;
	endtask

	task automatic new_working_set();
		foreach (tag_pool[i])
			tag_pool[i] = $urandom_range(UNCACHED_BASE / (LINES * LINE_BYTES) - 1, 0);
		foreach (idx_pool[i])
			idx_pool[i] = $urandom_range(LINES - 1, 0);
	endtask

	// Mostly cacheable fetches within the working set, some uncached ones and some
	// fully random 32-bit addresses, which also exercise the ignored low bits.
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned sel;
		logic [ADDR_W-1:0] addr;
		sel = $urandom_range(99);
		if (sel < 60) begin
			addr = tag_pool[$urandom_range(3)] * (LINES * LINE_BYTES)
				+ idx_pool[$urandom_range(7)] * LINE_BYTES
				+ $urandom_range(WORDS_PER_LINE - 1) * 4;
			if ($urandom_range(9) == 0)
				addr[1:0] = 2'($urandom_range(3));
		end else if (sel < 75) begin
			addr = UNCACHED_BASE + $urandom_range(32'h5FFF_FFFF, 0);
		end else begin
			addr = $urandom();
		end
		return addr;
	endfunction

	// Random traffic for one configuration. A good share is sequential instruction
	// streams, which walk across line boundaries and hit on the refilled words. Half
	// way through, the sender holds off until every result is back.
	task automatic run_random(input int unsigned n_items, input int unsigned quiet_items);
		int unsigned sent;
		int unsigned run_len;
		logic [ADDR_W-1:0] base;
		bit paused;
		sent = 0;
		paused = 1'b0;
		new_working_set();
		while (sent < n_items) begin
			gaps_on = (sent >= quiet_items);
			if ($urandom_range(99) < 30) begin
				base = pick_address();
				base[1:0] = 2'b00;
				run_len = $urandom_range(8, 3);
				for (int k = 0; k < run_len; k++)
					send_fetch(base + 4 * k);
				sent += run_len;
			end else begin
				send_fetch(pick_address());
				sent++;
			end
			if (!paused && sent >= n_items / 2) begin
				drain();
				paused = 1'b1;
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with the reset configuration (enabled, not held). The first
		// fetches wait out the clearing pass through the busy handshake.
		send_fetch(32'h0000_0000);  // cold miss at word zero: full refill
		send_fetch(32'h0000_0004);  // hit on the refilled line
		send_fetch(32'h0000_000C);
		send_fetch(32'h0000_1008);  // same line, other tag, word two: partial refill
		send_fetch(32'h0000_1000);  // word below the refill point stays invalid
		send_fetch(32'h0000_000C);  // first tag was evicted
		send_fetch(32'h9FFF_FFFC);  // highest cacheable word, last line
		send_fetch(32'h9FFF_FFFC);
		send_fetch(32'hA000_0000);  // lowest uncached address
		send_fetch(32'hA000_0000);  // uncached never fills, so it misses again
		send_fetch(32'hFFFF_FFFC);
		send_fetch(32'h0000_2003);  // unaligned: low bits ignored
		send_fetch(32'h0000_2005);
		send_fetch(32'h0000_0FF0);  // last line index with a zero tag
		send_fetch(32'h0000_0FFE);

		// Disabled, held, and both: results are zero and nothing is filled.
		apply_setting(1'b0, 1'b0);
		send_fetch(32'h0000_3000);
		send_fetch(32'h0000_0004);
		apply_setting(1'b1, 1'b1);
		send_fetch(32'h0000_3000);
		send_fetch(32'h0000_0FF0);
		apply_setting(1'b0, 1'b1);
		send_fetch(32'h0000_3000);
		apply_setting(1'b1, 1'b0);
		send_fetch(32'h0000_3000);  // must still miss
		send_fetch(32'h0000_0FF0);  // must still hit

		// Random part across the configurations; the last run opens with a stretch of
		// back-to-back fetches.
		run_random(180, 0);
		apply_setting(1'b0, 1'b0);
		run_random(30, 0);
		apply_setting(1'b1, 1'b1);
		run_random(30, 0);
		apply_setting(1'b0, 1'b1);
		run_random(20, 0);
		apply_setting(1'b1, 1'b0);
		run_random(240, 100);

		drain();
		$display("Sent %0d fetches over %0d register settings: %0d hits, %0d refills,",
			fetches_sent, settings_seen + 1, sb.hits, sb.refills);
		$display("%0d uncached misses and %0d inert fetches; %0d mismatches.",
			sb.uncached_misses, sb.inert, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/icfc_pkg.sv
hdl/icfc_ram.sv
hdl/icfc_ctrl.sv
hdl/icfc_dp.sv
hdl/icache_fetch_cost_model_core.sv
hdl/icfc_checker.sv
tb/tb_icache_fetch_cost_model_core.sv
